// ===== rtl/pss_pkg.sv =====
// pss_pkg: types, codes and character-class helpers for the printf specifier scanner
// used by rtl/printf_spec_scanner.sv; no dependencies
package pss_pkg;

    // one transaction on the input channel: one byte of the format string
    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } t_in;

    // one transaction on the output channel: a token or an end-of-string report
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] conv_char;
        logic [7:0] mod_first;
        logic [7:0] mod_second;
        logic       mod_overflow;
        logic       run_end;
    } t_out;

    localparam logic [1:0] KIND_SPEC    = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_BAD = 2'd2;

    localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
    localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
    localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'
    localparam logic [7:0] CH_D    = 8'h64;  // 'd'
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef enum logic [3:0] {
        PH_TEXT   = 4'd0,
        PH_PCT    = 4'd1,
        PH_FLAGS  = 4'd2,
        PH_WIDTH  = 4'd3,
        PH_WSTAR  = 4'd4,
        PH_DOT    = 4'd5,
        PH_PREC   = 4'd6,
        PH_LEN    = 4'd7,
        PH_AFTERW = 4'd8
    } t_phase;

    function automatic logic is_flag(input logic [7:0] c);
        logic r;
        case (c) inside
            "-", "+", " ", "#", "0": r = 1'b1;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_len(input logic [7:0] c);
        logic r;
        case (c) inside
            "h", "l", "j", "z", "t", "L": r = 1'b1;
            default:                      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_conv(input logic [7:0] c);
        logic r;
        case (c) inside
            "d", "i", "o", "u", "x", "X", "e", "E", "f", "F",
            "g", "G", "a", "A", "c", "s", "p": r = 1'b1;
            default:                          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/printf_spec_scanner.sv =====
// printf_spec_scanner: scans printf conversion specifiers one byte per transaction
// depends on rtl/pss_pkg.sv
//
//  channel | direction | payload       | handshake
//  in      | input     | pss_pkg::t_in  | i_in_valid / o_in_stall
//  out     | output    | pss_pkg::t_out | o_out_valid / i_out_stall
//
// each byte is decoded in the cycle it is accepted and its 0..2 results are
// written into a 4-entry result queue; the queue head drives the output port
// one byte per cycle while each byte yields at most one result and i_out_stall
// is low; a byte that yields two results also needs a second output transfer
// input stalls while fewer than two queue entries are free
// reset (synchronous, i_rst_n low) empties the queue and returns the scanner
// to plain text with no held modifiers and no error

module printf_spec_scanner #(
    parameter int MAX_MOD_CHARS = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pss_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pss_pkg::t_out  o_out_data
);

    localparam int CW = $clog2(MAX_MOD_CHARS + 2);
    localparam logic [CW-1:0] MOD_LIM = CW'(MAX_MOD_CHARS);
    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    // scanner state
    pss_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_mod1, n_mod1;
    logic [7:0]      r_mod2, n_mod2;
    logic [CW-1:0]   r_mod_cnt, n_mod_cnt;
    logic            r_err, n_err;

    // result queue
    pss_pkg::t_out   r_q [QD];
    logic [QW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QW:0]     r_count, n_count;

    logic            in_acc, out_acc;
    logic            tok_valid;
    pss_pkg::t_out   tok, end_res, res0, res1;
    logic [1:0]      push_n;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_count > (QW+1)'(QD - 2);
    assign o_out_valid = r_count != '0;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_data  = r_q[r_rd_ptr];

    // single-pass decode of one byte against the current phase
    always_comb begin
        pss_pkg::t_phase cur;
        logic            done;
        logic [7:0]      c;
        c         = i_in_data.ch;
        cur       = r_phase;
        done      = 1'b0;
        n_phase   = r_phase;
        n_mod1    = r_mod1;
        n_mod2    = r_mod2;
        n_mod_cnt = r_mod_cnt;
        n_err     = r_err;
        tok_valid = 1'b0;
        tok       = '{kind: pss_pkg::KIND_SPEC, conv_char: pss_pkg::CH_D,
                      mod_first: pss_pkg::CH_NUL, mod_second: pss_pkg::CH_NUL,
                      mod_overflow: 1'b0, run_end: 1'b0};

        if (!r_err) begin
            if (cur == pss_pkg::PH_PCT) begin
                if (c == pss_pkg::CH_PCT) begin
                    n_phase = pss_pkg::PH_TEXT;
                    done    = 1'b1;
                end else begin
                    cur = pss_pkg::PH_FLAGS;
                end
            end
            if (!done && cur == pss_pkg::PH_FLAGS) begin
                if (pss_pkg::is_flag(c)) begin
                    n_phase = pss_pkg::PH_FLAGS;
                    done    = 1'b1;
                end else if (c == pss_pkg::CH_STAR) begin
                    tok_valid = 1'b1;
                    n_phase   = pss_pkg::PH_WSTAR;
                    done      = 1'b1;
                end else if (pss_pkg::is_digit(c)) begin
                    n_phase = pss_pkg::PH_WIDTH;
                    done    = 1'b1;
                end else begin
                    cur = pss_pkg::PH_AFTERW;
                end
            end
            if (!done && cur == pss_pkg::PH_WIDTH) begin
                if (pss_pkg::is_digit(c)) begin
                    done = 1'b1;
                end else begin
                    cur = pss_pkg::PH_AFTERW;
                end
            end
            if (!done && cur == pss_pkg::PH_WSTAR) begin
                cur = pss_pkg::PH_AFTERW;
            end
            if (!done && cur == pss_pkg::PH_AFTERW) begin
                if (c == pss_pkg::CH_DOT) begin
                    n_phase = pss_pkg::PH_DOT;
                    done    = 1'b1;
                end else begin
                    cur = pss_pkg::PH_LEN;
                end
            end
            if (!done && cur == pss_pkg::PH_DOT) begin
                if (c == pss_pkg::CH_STAR) begin
                    tok_valid = 1'b1;
                    n_phase   = pss_pkg::PH_LEN;
                    done      = 1'b1;
                end else if (pss_pkg::is_digit(c)) begin
                    n_phase = pss_pkg::PH_PREC;
                    done    = 1'b1;
                end else begin
                    cur = pss_pkg::PH_LEN;
                end
            end
            if (!done && cur == pss_pkg::PH_PREC) begin
                if (pss_pkg::is_digit(c)) begin
                    done = 1'b1;
                end else begin
                    cur = pss_pkg::PH_LEN;
                end
            end
            if (!done && cur == pss_pkg::PH_LEN) begin
                done = 1'b1;
                if (pss_pkg::is_len(c)) begin
                    if (r_mod_cnt == CW'(0)) begin
                        n_mod1 = c;
                    end else if (r_mod_cnt == CW'(1)) begin
                        n_mod2 = c;
                    end
                    if (r_mod_cnt <= MOD_LIM) begin
                        n_mod_cnt = r_mod_cnt + CW'(1);
                    end
                    n_phase = pss_pkg::PH_LEN;
                end else if (pss_pkg::is_conv(c)) begin
                    tok_valid        = 1'b1;
                    tok.conv_char    = c;
                    tok.mod_first    = r_mod1;
                    tok.mod_second   = r_mod2;
                    tok.mod_overflow = r_mod_cnt > MOD_LIM;
                    n_mod1           = '0;
                    n_mod2           = '0;
                    n_mod_cnt        = '0;
                    n_phase          = pss_pkg::PH_TEXT;
                end else begin
                    n_err = 1'b1;
                end
            end
            // plain text and any unused phase code
            if (!done) begin
                n_phase = (c == pss_pkg::CH_PCT) ? pss_pkg::PH_PCT : pss_pkg::PH_TEXT;
            end
        end

        end_res = '{kind: (!n_err && n_phase == pss_pkg::PH_TEXT) ?
                          pss_pkg::KIND_END_OK : pss_pkg::KIND_END_BAD,
                    conv_char: pss_pkg::CH_NUL, mod_first: pss_pkg::CH_NUL,
                    mod_second: pss_pkg::CH_NUL, mod_overflow: 1'b0, run_end: 1'b1};

        // end of string puts every piece of scanner state back to its reset value
        if (i_in_data.final_byte) begin
            n_phase   = pss_pkg::PH_TEXT;
            n_mod1    = '0;
            n_mod2    = '0;
            n_mod_cnt = '0;
            n_err     = 1'b0;
        end

        tok.run_end = !i_in_data.final_byte;
        res0        = tok_valid ? tok : end_res;
        res1        = end_res;
        push_n      = in_acc ? (2'(tok_valid) + 2'(i_in_data.final_byte)) : 2'd0;
        n_count     = r_count + (QW+1)'(push_n) - (QW+1)'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pss_pkg::PH_TEXT;
            r_mod1    <= '0;
            r_mod2    <= '0;
            r_mod_cnt <= '0;
            r_err     <= 1'b0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            if (in_acc) begin
                r_phase   <= n_phase;
                r_mod1    <= n_mod1;
                r_mod2    <= n_mod2;
                r_mod_cnt <= n_mod_cnt;
                r_err     <= n_err;
            end
            r_wr_ptr <= r_wr_ptr + QW'(push_n);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            r_count <= n_count;
        end
    end

    // queue payload, written only into free entries so the head holds while stalled
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr_ptr + QW'(1)] <= res1;
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QW+1)'(QD))
        else $error("result queue over capacity");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.final_byte |=>
            r_phase == pss_pkg::PH_TEXT && !r_err && r_mod_cnt == '0)
        else $error("scanner state not cleared after end of string");

    a_mod_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod_cnt <= MOD_LIM + CW'(1))
        else $error("modifier count past saturation");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != pss_pkg::KIND_SPEC |-> o_out_data.run_end)
        else $error("end report not marked as last result");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for printf_spec_scanner, format strings fed one byte per transaction
// depends on rtl/pss_pkg.sv and rtl/printf_spec_scanner.sv
module tb;

    localparam int MOD_KEEP   = 2;
    localparam int CYCLE_CAP  = 600000;
    localparam int RAND_BYTES = 1150;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          o_in_stall;
    pss_pkg::t_in  in_data = '0;
    logic          o_out_valid;
    logic          out_stall = 1'b0;
    pss_pkg::t_out out_data;

    printf_spec_scanner #(.MAX_MOD_CHARS(MOD_KEEP)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // byte stream still to send, tokens still to arrive
    pss_pkg::t_in  fmt_bytes[$];
    pss_pkg::t_out fmt_results[$];
    int            drain_marks[$];
    logic [7:0]    str_buf[$];

    string flag_chars = "-+ #0";
    string len_chars  = "hljztL";
    string conv_chars = "diouxXeEfFgGaAcsp";

    // scanner state as predicted
    pss_pkg::t_phase scan_ph     = pss_pkg::PH_TEXT;
    logic [7:0]      held_first  = 8'd0;
    logic [7:0]      held_second = 8'd0;
    logic [1:0]      held_cnt    = 2'd0;
    logic            scan_err    = 1'b0;

    int   taken_cnt   = 0;
    int   calm_from   = 32'h7fffffff;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   gap_pct     = 10;
    int   stall_pct   = 10;
    int   bad_results = 0;
    int   cycles      = 0;
    logic byte_taken  = 1'b0;
    logic calm;

    assign calm = (taken_cnt >= calm_from);

    function automatic logic char_in(input logic [7:0] c, input string set);
        for (int i = 0; i < set.len(); i++)
            if (8'(set[i]) == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic pss_pkg::t_out make_tok(input logic [1:0] k, input logic [7:0] conv,
                                               input logic [7:0] m1, input logic [7:0] m2,
                                               input logic ovf);
        pss_pkg::t_out t;
        t.kind         = k;
        t.conv_char    = conv;
        t.mod_first    = m1;
        t.mod_second   = m2;
        t.mod_overflow = ovf;
        t.run_end      = 1'b0;
        return t;
    endfunction

    task automatic clear_mods();
        held_first  = 8'd0;
        held_second = 8'd0;
        held_cnt    = 2'd0;
    endtask

    task automatic add_byte(input logic [7:0] c);
        str_buf = {str_buf, c};
    endtask

    task automatic mark_drain(input int n);
        drain_marks = {drain_marks, n};
    endtask

    // advance the scanner by one byte and queue the tokens it produces
    task automatic scan_fmt_byte(input pss_pkg::t_in b);
        pss_pkg::t_out   toks[$];
        pss_pkg::t_out   last;
        pss_pkg::t_phase ph;
        logic            done;
        ph   = scan_ph;
        done = 1'b0;
        if (!scan_err) begin
            if (ph == pss_pkg::PH_PCT) begin
                if (b.ch == pss_pkg::CH_PCT) begin
                    scan_ph = pss_pkg::PH_TEXT;
                    done    = 1'b1;
                end else begin
                    ph = pss_pkg::PH_FLAGS;
                end
            end
            if (!done && ph == pss_pkg::PH_FLAGS) begin
                done = 1'b1;
                if (char_in(b.ch, flag_chars)) begin
                    scan_ph = pss_pkg::PH_FLAGS;
                end else if (b.ch == pss_pkg::CH_STAR) begin
                    toks = {toks, make_tok(pss_pkg::KIND_SPEC, pss_pkg::CH_D,
                                           pss_pkg::CH_NUL, pss_pkg::CH_NUL, 1'b0)};
                    scan_ph = pss_pkg::PH_WSTAR;
                end else if (is_num(b.ch)) begin
                    scan_ph = pss_pkg::PH_WIDTH;
                end else begin
                    ph   = pss_pkg::PH_AFTERW;
                    done = 1'b0;
                end
            end
            if (!done && ph == pss_pkg::PH_WIDTH) begin
                if (is_num(b.ch)) done = 1'b1;
                else ph = pss_pkg::PH_AFTERW;
            end
            if (!done && ph == pss_pkg::PH_WSTAR) ph = pss_pkg::PH_AFTERW;
            if (!done && ph == pss_pkg::PH_AFTERW) begin
                if (b.ch == pss_pkg::CH_DOT) begin
                    scan_ph = pss_pkg::PH_DOT;
                    done    = 1'b1;
                end else begin
                    ph = pss_pkg::PH_LEN;
                end
            end
            if (!done && ph == pss_pkg::PH_DOT) begin
                done = 1'b1;
                if (b.ch == pss_pkg::CH_STAR) begin
                    toks = {toks, make_tok(pss_pkg::KIND_SPEC, pss_pkg::CH_D,
                                           pss_pkg::CH_NUL, pss_pkg::CH_NUL, 1'b0)};
                    scan_ph = pss_pkg::PH_LEN;
                end else if (is_num(b.ch)) begin
                    scan_ph = pss_pkg::PH_PREC;
                end else begin
                    ph   = pss_pkg::PH_LEN;
                    done = 1'b0;
                end
            end
            if (!done && ph == pss_pkg::PH_PREC) begin
                if (is_num(b.ch)) done = 1'b1;
                else ph = pss_pkg::PH_LEN;
            end
            if (!done && ph == pss_pkg::PH_LEN) begin
                done = 1'b1;
                if (char_in(b.ch, len_chars)) begin
                    if (held_cnt == 2'd0) held_first = b.ch;
                    else if (held_cnt == 2'd1) held_second = b.ch;
                    if (held_cnt <= MOD_KEEP) held_cnt++;
                    scan_ph = pss_pkg::PH_LEN;
                end else if (char_in(b.ch, conv_chars)) begin
                    toks = {toks, make_tok(pss_pkg::KIND_SPEC, b.ch, held_first,
                                           held_second, held_cnt > MOD_KEEP)};
                    clear_mods();
                    scan_ph = pss_pkg::PH_TEXT;
                end else begin
                    scan_err = 1'b1;
                end
            end
            if (!done) begin
                if (b.ch == pss_pkg::CH_PCT) scan_ph = pss_pkg::PH_PCT;
                else scan_ph = pss_pkg::PH_TEXT;
            end
        end
        if (b.final_byte) begin
            if (!scan_err && scan_ph == pss_pkg::PH_TEXT)
                toks = {toks, make_tok(pss_pkg::KIND_END_OK, pss_pkg::CH_NUL,
                                       pss_pkg::CH_NUL, pss_pkg::CH_NUL, 1'b0)};
            else
                toks = {toks, make_tok(pss_pkg::KIND_END_BAD, pss_pkg::CH_NUL,
                                       pss_pkg::CH_NUL, pss_pkg::CH_NUL, 1'b0)};
            clear_mods();
            scan_ph  = pss_pkg::PH_TEXT;
            scan_err = 1'b0;
        end
        if (toks.size() > 0) begin
            last = toks.pop_back();
            last.run_end = 1'b1;
            toks = {toks, last};
        end
        foreach (toks[i]) fmt_results = {fmt_results, toks[i]};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
    endtask

    task automatic close_string();
        pss_pkg::t_in b;
        foreach (str_buf[i]) begin
            b.ch         = str_buf[i];
            b.final_byte = (i == str_buf.size() - 1);
            fmt_bytes    = {fmt_bytes, b};
        end
        str_buf.delete();
    endtask

    task automatic pick_char(input string set);
        add_byte(8'(set[$urandom_range(0, set.len() - 1)]));
    endtask

    // one conversion specifier, mostly well formed
    task automatic gen_spec();
        int r;
        add_byte(pss_pkg::CH_PCT);
        if ($urandom_range(0, 9) == 0) begin
            add_byte(pss_pkg::CH_PCT);
            return;
        end
        repeat ($urandom_range(0, 3)) pick_char(flag_chars);
        r = $urandom_range(0, 3);
        if (r == 1) add_byte(pss_pkg::CH_STAR);
        else if (r > 1) repeat ($urandom_range(1, 3)) pick_char("0123456789");
        if ($urandom_range(0, 2) == 0) begin
            add_byte(pss_pkg::CH_DOT);
            r = $urandom_range(0, 2);
            if (r == 1) add_byte(pss_pkg::CH_STAR);
            else if (r == 2) repeat ($urandom_range(1, 2)) pick_char("0123456789");
        end
        r = $urandom_range(0, 9);
        if (r >= 5) repeat ((r < 7) ? 1 : (r < 9) ? 2 : $urandom_range(3, 4))
            pick_char(len_chars);
        if ($urandom_range(0, 11) == 0) add_byte(8'($urandom_range(0, 255)));
        else pick_char(conv_chars);
    endtask

    initial begin : stimulus
        int next_drain;
        int rand_end;
        // directed strings: stars, long modifiers, escaped percent, truncation, bad conversion
        add_text("%-*.*lld"); close_string();
        add_text("%jztp");    close_string();
        add_text("%%");       close_string();
        add_text("a%");       close_string();
        add_text("%q");       close_string();
        add_text("%*");       close_string();
        add_byte(8'h00); add_byte(8'hFF); close_string();
        add_byte(8'hFF); close_string();
        mark_drain(fmt_bytes.size());
        next_drain = fmt_bytes.size() + 400;
        rand_end   = fmt_bytes.size() + RAND_BYTES;

        while (fmt_bytes.size() < rand_end) begin
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) < 6) gen_spec();
                    else repeat ($urandom_range(1, 3))
                        add_byte(8'($urandom_range(0, 255)));
                end
                // cut the string short, often inside a specifier
                if ($urandom_range(0, 9) == 0 && str_buf.size() > 1)
                    repeat ($urandom_range(1, str_buf.size() - 1)) void'(str_buf.pop_back());
            end
            close_string();
            if (fmt_bytes.size() >= next_drain) begin
                mark_drain(fmt_bytes.size());
                next_drain += 400;
            end
        end
        calm_from = fmt_bytes.size() - 150;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (fmt_bytes.size() != 0 || fmt_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (bad_results == 0 && fmt_results.size() == 0)
            $display("printf_spec_scanner regression: pass");
        else
            $display("printf_spec_scanner regression: fail");
        $finish;
    end

    // byte driver
    always @(negedge i_clk) begin : feed_bytes
        logic nv;
        nv = in_valid;
        if (i_rst_n && (!in_valid || byte_taken)) begin
            nv = 1'b0;
            if (drain_marks.size() > 0 && taken_cnt == drain_marks[0]
                && fmt_results.size() == 0)
                void'(drain_marks.pop_front());
            if (gap_left > 0) begin
                gap_left--;
            end else if (fmt_bytes.size() > 0
                         && !(drain_marks.size() > 0 && taken_cnt == drain_marks[0])) begin
                if (!calm && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(0, 16);
                end else begin
                    nv = 1'b1;
                    in_data <= fmt_bytes[0];
                end
            end
        end
        byte_taken = 1'b0;
        in_valid  <= nv;
    end

    // receiver stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 16);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // accepted byte transaction: predict its tokens
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            scan_fmt_byte(in_data);
            void'(fmt_bytes.pop_front());
            byte_taken = 1'b1;
            taken_cnt++;
            if (taken_cnt % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 6;
                    default: gap_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 6;
                    default: stall_pct = 30;
                endcase
            end
        end
    end

    // token monitor
    always @(posedge i_clk) begin : check_tokens
        pss_pkg::t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (fmt_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected token: kind %0d conv %h mods %h %h ovf %b end %b",
                             out_data.kind, out_data.conv_char, out_data.mod_first,
                             out_data.mod_second, out_data.mod_overflow, out_data.run_end);
            end else begin
                want = fmt_results.pop_front();
                if (out_data.kind !== want.kind || out_data.conv_char !== want.conv_char
                    || out_data.mod_first !== want.mod_first
                    || out_data.mod_second !== want.mod_second
                    || out_data.mod_overflow !== want.mod_overflow
                    || out_data.run_end !== want.run_end) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $write("token mismatch: kind %0d/%0d conv %h/%h mod1 %h/%h ",
                               want.kind, out_data.kind, want.conv_char, out_data.conv_char,
                               want.mod_first, out_data.mod_first);
                        $display("mod2 %h/%h ovf %b/%b end %b/%b (expected/actual)",
                                 want.mod_second, out_data.mod_second,
                                 want.mod_overflow, out_data.mod_overflow,
                                 want.run_end, out_data.run_end);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("printf_spec_scanner regression: fail");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/pss_pkg.sv
rtl/printf_spec_scanner.sv
sim/tb.sv
